// ===== rtl/deq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_pkg
// Shared types and defaults for the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

    localparam int DEPTH_DEF      = 64;
    localparam int DATA_WIDTH_DEF = 32;

    localparam int OP_W   = 3;
    localparam int POS_W  = 7;
    localparam int VAL_W  = 32;
    localparam int OCC_W  = 7;
    localparam int STAT_W = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 3'd0,
        OP_PUSH_FRONT = 3'd1,
        OP_POP_BACK   = 3'd2,
        OP_POP_FRONT  = 3'd3,
        OP_READ_AT    = 3'd4,
        OP_INSERT_AT  = 3'd5,
        OP_ERASE_AT   = 3'd6
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_INS_WR,
        S_FINISH
    } state_t;

endpackage
`default_nettype wire

// ===== rtl/deq_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// deq_store
// Element storage: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module deq_store #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF,
    localparam int AW        = $clog2(DEPTH)
) (
    input  wire logic                  aclk,
    input  wire logic                  wr_en,
    input  wire logic [AW-1:0]         wr_addr,
    input  wire logic [DATA_WIDTH-1:0] wr_data,
    input  wire logic                  rd_en,
    input  wire logic [AW-1:0]         rd_addr,
    output logic      [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

// ===== rtl/double_ended_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// double_ended_queue
// Fixed-capacity deque kept as a ring (head pointer + count) in one RAM.
// Push, pop, read, insert at the back, erase of the last element and error cases go
// from idle straight to the finish state; other inserts and erases first shift elements:
// each shifted element costs one RAM read then one RAM write via the shared slot adder.
// One item at a time; a new item is taken while the last result waits.
// Reset (aresetn, sync): empty queue, head at slot 0; RAM contents not cleared.
// ----------------------------------------------------------------------------
module double_ended_queue #(
    parameter int DEPTH      = deq_pkg::DEPTH_DEF,
    parameter int DATA_WIDTH = deq_pkg::DATA_WIDTH_DEF
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       s_valid,
    output logic                            s_ready,
    input  wire logic [deq_pkg::OP_W-1:0]   s_operation,
    input  wire logic [deq_pkg::POS_W-1:0]  s_position,
    input  wire logic [deq_pkg::VAL_W-1:0]  s_value,
    output logic                            m_valid,
    input  wire logic                       m_ready,
    output logic [deq_pkg::VAL_W-1:0]       m_data_out,
    output logic [deq_pkg::STAT_W-1:0]      m_status,
    output logic [deq_pkg::OCC_W-1:0]       m_occupancy
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int SW = CW + 1;
    localparam int PW = (CW > deq_pkg::POS_W) ? CW : deq_pkg::POS_W;

    deq_pkg::state_t  state_reg, state_next;
    deq_pkg::op_t     op_reg, op_next;
    deq_pkg::status_t status_reg, status_next;
    logic [AW-1:0]    head_reg, head_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    idx_reg, idx_next;
    logic [CW-1:0]    pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic             rd_sel_reg, rd_sel_next;

    logic                        m_valid_reg, m_valid_next;
    logic [deq_pkg::VAL_W-1:0]   m_data_out_reg, m_data_out_next;
    deq_pkg::status_t            m_status_reg, m_status_next;
    logic [deq_pkg::OCC_W-1:0]   m_occupancy_reg, m_occupancy_next;

    logic                  mem_wr_en, mem_rd_en;
    logic [AW-1:0]         mem_wr_addr, mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data, mem_rd_data;

    logic [CW-1:0] slot_idx;
    logic [SW-1:0] slot_sum;
    logic [AW-1:0] slot;
    logic [AW-1:0] head_dec, head_inc;
    logic [PW-1:0] pos_w, count_w;
    logic          accept, full, empty;

    // shared ring address unit: slot = (head + idx) mod DEPTH
    assign slot_sum = SW'(head_reg) + SW'(slot_idx);
    assign slot     = (slot_sum >= SW'(DEPTH)) ? AW'(slot_sum - SW'(DEPTH)) : AW'(slot_sum);

    assign head_dec = (head_reg == '0) ? AW'(DEPTH - 1) : head_reg - 1'b1;
    assign head_inc = (head_reg == AW'(DEPTH - 1)) ? '0 : head_reg + 1'b1;

    assign pos_w   = PW'(s_position);
    assign count_w = PW'(count_reg);
    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);

    assign s_ready = (state_reg == deq_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;

    deq_store #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_store (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= deq_pkg::S_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        op_reg          <= op_next;
        status_reg      <= status_next;
        idx_reg         <= idx_next;
        pos_reg         <= pos_next;
        val_reg         <= val_next;
        rd_sel_reg      <= rd_sel_next;
        m_data_out_reg  <= m_data_out_next;
        m_status_reg    <= m_status_next;
        m_occupancy_reg <= m_occupancy_next;
    end

    always_comb begin
        state_next       = state_reg;
        op_next          = op_reg;
        status_next      = status_reg;
        head_next        = head_reg;
        count_next       = count_reg;
        idx_next         = idx_reg;
        pos_next         = pos_reg;
        val_next         = val_reg;
        rd_sel_next      = rd_sel_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_data_out_next  = m_data_out_reg;
        m_status_next    = m_status_reg;
        m_occupancy_next = m_occupancy_reg;
        slot_idx         = idx_reg;
        mem_wr_en        = 1'b0;
        mem_rd_en        = 1'b0;
        mem_wr_addr      = slot;
        mem_rd_addr      = slot;
        mem_wr_data      = val_reg;

        unique case (state_reg)
            deq_pkg::S_IDLE: begin
                if (accept) begin
                    op_next     = deq_pkg::op_t'(s_operation);
                    pos_next    = CW'(s_position);
                    val_next    = DATA_WIDTH'(s_value);
                    status_next = deq_pkg::ST_OK;
                    rd_sel_next = 1'b0;
                    state_next  = deq_pkg::S_FINISH;
                    mem_wr_data = DATA_WIDTH'(s_value);
                    unique case (deq_pkg::op_t'(s_operation))
                        deq_pkg::OP_PUSH_BACK: begin
                            if (full) begin
                                status_next = deq_pkg::ST_FULL;
                            end else begin
                                slot_idx   = count_reg;
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_PUSH_FRONT: begin
                            if (full) begin
                                status_next = deq_pkg::ST_FULL;
                            end else begin
                                head_next   = head_dec;
                                mem_wr_addr = head_dec;
                                mem_wr_en   = 1'b1;
                                count_next  = count_reg + 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_BACK: begin
                            if (empty) begin
                                status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                slot_idx    = count_reg - 1'b1;
                                mem_rd_en   = 1'b1;
                                rd_sel_next = 1'b1;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_POP_FRONT: begin
                            if (empty) begin
                                status_next = deq_pkg::ST_EMPTY;
                            end else begin
                                mem_rd_addr = head_reg;
                                mem_rd_en   = 1'b1;
                                rd_sel_next = 1'b1;
                                head_next   = head_inc;
                                count_next  = count_reg - 1'b1;
                            end
                        end
                        deq_pkg::OP_READ_AT: begin
                            if (empty) begin
                                status_next = deq_pkg::ST_EMPTY;
                            end else if (pos_w >= count_w) begin
                                status_next = deq_pkg::ST_RANGE;
                            end else begin
                                slot_idx    = CW'(s_position);
                                mem_rd_en   = 1'b1;
                                rd_sel_next = 1'b1;
                            end
                        end
                        deq_pkg::OP_INSERT_AT: begin
                            if (full) begin
                                status_next = deq_pkg::ST_FULL;
                            end else if (pos_w > count_w) begin
                                status_next = deq_pkg::ST_RANGE;
                            end else if (pos_w == count_w) begin
                                slot_idx   = CW'(s_position);
                                mem_wr_en  = 1'b1;
                                count_next = count_reg + 1'b1;
                            end else begin
                                idx_next   = count_reg;
                                state_next = deq_pkg::S_SHIFT_RD;
                            end
                        end
                        deq_pkg::OP_ERASE_AT: begin
                            if (pos_w >= count_w) begin
                                status_next = deq_pkg::ST_RANGE;
                            end else if (pos_w == count_w - 1'b1) begin
                                count_next = count_reg - 1'b1;
                            end else begin
                                idx_next   = CW'(s_position);
                                state_next = deq_pkg::S_SHIFT_RD;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            deq_pkg::S_SHIFT_RD: begin
                // insert moves toward the back, erase toward the front
                slot_idx   = (op_reg == deq_pkg::OP_INSERT_AT) ? idx_reg - 1'b1
                                                               : idx_reg + 1'b1;
                mem_rd_en  = 1'b1;
                state_next = deq_pkg::S_SHIFT_WR;
            end
            deq_pkg::S_SHIFT_WR: begin
                mem_wr_en   = 1'b1;
                mem_wr_data = mem_rd_data;
                if (op_reg == deq_pkg::OP_INSERT_AT) begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = (idx_reg - 1'b1 == pos_reg) ? deq_pkg::S_INS_WR
                                                             : deq_pkg::S_SHIFT_RD;
                end else begin
                    idx_next = idx_reg + 1'b1;
                    if (SW'(idx_reg) + SW'(2) >= SW'(count_reg)) begin
                        count_next = count_reg - 1'b1;
                        state_next = deq_pkg::S_FINISH;
                    end else begin
                        state_next = deq_pkg::S_SHIFT_RD;
                    end
                end
            end
            deq_pkg::S_INS_WR: begin
                slot_idx   = pos_reg;
                mem_wr_en  = 1'b1;
                count_next = count_reg + 1'b1;
                state_next = deq_pkg::S_FINISH;
            end
            deq_pkg::S_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_data_out_next  = rd_sel_reg ? deq_pkg::VAL_W'(mem_rd_data) : '0;
                    m_status_next    = status_reg;
                    m_occupancy_next = deq_pkg::OCC_W'(count_reg);
                    state_next       = deq_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = deq_pkg::S_IDLE;
            end
        endcase
    end

    assign m_valid     = m_valid_reg;
    assign m_data_out  = m_data_out_reg;
    assign m_status    = m_status_reg;
    assign m_occupancy = m_occupancy_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(DEPTH))
        else $error("element count above capacity");

    a_insert_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == deq_pkg::S_SHIFT_RD && op_reg == deq_pkg::OP_INSERT_AT)
        |-> (idx_reg > pos_reg && idx_reg <= count_reg))
        else $error("insert shift index out of bounds");

    a_erase_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == deq_pkg::S_SHIFT_RD && op_reg == deq_pkg::OP_ERASE_AT)
        |-> (SW'(idx_reg) + SW'(1) < SW'(count_reg)))
        else $error("erase shift index out of bounds");

    a_full_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == deq_pkg::ST_FULL)
        |-> (m_occupancy_reg == deq_pkg::OCC_W'(DEPTH)))
        else $error("full status with queue not full");

    a_empty_occ: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_status_reg == deq_pkg::ST_EMPTY) |-> (m_occupancy_reg == '0))
        else $error("empty status with queue not empty");

endmodule
`default_nettype wire

// ===== dv/tb_double_ended_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_double_ended_queue
// Self-checking bench for the ring-buffer deque. A shadow deque predicts data,
// status and occupancy for every accepted item. Each returned item is checked
// in order against those predictions. Covers the empty, full and
// out-of-range cases, then random traffic that swings between empty and full
// under several sender and receiver idle patterns.
// ----------------------------------------------------------------------------
module tb_double_ended_queue;

    localparam int           DEPTH        = deq_pkg::DEPTH_DEF;
    localparam int           DATA_WIDTH   = deq_pkg::DATA_WIDTH_DEF;
    localparam logic [2:0]   OP_UNDEFINED = 3'd7;
    localparam int           CYCLE_LIMIT  = 1_500_000;
    localparam int           MAX_REPORTS  = 10;

    typedef struct {
        logic [deq_pkg::VAL_W-1:0] data;
        deq_pkg::status_t          status;
        logic [deq_pkg::OCC_W-1:0] occupancy;
    } deq_result_t;

    logic                        aclk        = 1'b0;
    logic                        aresetn     = 1'b0;
    logic                        s_valid     = 1'b0;
    logic                        s_ready;
    logic [deq_pkg::OP_W-1:0]    s_operation = '0;
    logic [deq_pkg::POS_W-1:0]   s_position  = '0;
    logic [deq_pkg::VAL_W-1:0]   s_value     = '0;
    logic                        m_valid;
    logic                        m_ready     = 1'b0;
    logic [deq_pkg::VAL_W-1:0]   m_data_out;
    logic [deq_pkg::STAT_W-1:0]  m_status;
    logic [deq_pkg::OCC_W-1:0]   m_occupancy;

    // shadow deque state
    logic [deq_pkg::VAL_W-1:0]   shadow_store [DEPTH];
    logic [5:0]                  shadow_head  = '0;
    logic [deq_pkg::OCC_W-1:0]   shadow_count = '0;

    deq_result_t        pending_results [$];
    int                 err_count       = 0;
    int                 result_idx      = 0;
    int                 cycle_count     = 0;
    int                 send_idle_pct   = 0;
    int                 recv_idle_pct   = 0;

    double_ended_queue #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_operation (s_operation),
        .s_position  (s_position),
        .s_value     (s_value),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data_out  (m_data_out),
        .m_status    (m_status),
        .m_occupancy (m_occupancy)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("[double_ended_queue] ERROR");
            $finish;
        end
    end

    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic logic [5:0] ring_slot(input logic [deq_pkg::OCC_W-1:0] idx);
        return 6'(shadow_head + idx);
    endfunction

    function automatic deq_result_t apply_deque_op(input logic [deq_pkg::OP_W-1:0] op,
                                                   input logic [deq_pkg::POS_W-1:0] pos,
                                                   input logic [deq_pkg::VAL_W-1:0] val);
        deq_result_t res;
        logic        full;
        res.data   = '0;
        res.status = deq_pkg::ST_OK;
        full       = (shadow_count >= DEPTH);
        case (op)
            deq_pkg::OP_PUSH_BACK: begin
                if (full) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    shadow_store[ring_slot(shadow_count)] = val;
                    shadow_count++;
                end
            end
            deq_pkg::OP_PUSH_FRONT: begin
                if (full) begin
                    res.status = deq_pkg::ST_FULL;
                end else begin
                    shadow_head = shadow_head - 6'd1;
                    shadow_store[shadow_head] = val;
                    shadow_count++;
                end
            end
            deq_pkg::OP_POP_BACK: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_store[ring_slot(shadow_count - 7'd1)];
                    shadow_count--;
                end
            end
            deq_pkg::OP_POP_FRONT: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else begin
                    res.data = shadow_store[shadow_head];
                    shadow_head = shadow_head + 6'd1;
                    shadow_count--;
                end
            end
            deq_pkg::OP_READ_AT: begin
                if (shadow_count == 0) begin
                    res.status = deq_pkg::ST_EMPTY;
                end else if (pos >= shadow_count) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    res.data = shadow_store[ring_slot(pos)];
                end
            end
            deq_pkg::OP_INSERT_AT: begin
                if (full) begin
                    res.status = deq_pkg::ST_FULL;
                end else if (pos > shadow_count) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    for (int i = shadow_count; i > pos; i--)
                        shadow_store[ring_slot(7'(i))] = shadow_store[ring_slot(7'(i - 1))];
                    shadow_store[ring_slot(pos)] = val;
                    shadow_count++;
                end
            end
            deq_pkg::OP_ERASE_AT: begin
                if (pos >= shadow_count) begin
                    res.status = deq_pkg::ST_RANGE;
                end else begin
                    for (int i = pos; i + 1 < shadow_count; i++)
                        shadow_store[ring_slot(7'(i))] = shadow_store[ring_slot(7'(i + 1))];
                    shadow_count--;
                end
            end
            default: begin
            end
        endcase
        res.occupancy = shadow_count;
        return res;
    endfunction

    function automatic void report_error(input string msg);
        err_count++;
        if (err_count <= MAX_REPORTS)
            $display("mismatch: %s", msg);
    endfunction

    // check returned items first, then predict the item accepted at this edge
    always @(posedge aclk) begin
        deq_result_t want;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    report_error($sformatf("item %0d unexpected: data=%h status=%0d occ=%0d",
                                           result_idx, m_data_out, m_status, m_occupancy));
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (m_data_out !== want.data)
                        report_error($sformatf("item %0d data: expected %h, got %h",
                                               result_idx, want.data, m_data_out));
                    if (m_status !== want.status)
                        report_error($sformatf("item %0d status: expected %0d, got %0d",
                                               result_idx, want.status, m_status));
                    if (m_occupancy !== want.occupancy)
                        report_error($sformatf("item %0d occupancy: expected %0d, got %0d",
                                               result_idx, want.occupancy, m_occupancy));
                end
                result_idx++;
            end
            if (s_valid && s_ready)
                pending_results.insert(pending_results.size(),
                                       apply_deque_op(s_operation, s_position, s_value));
        end
    end

    task automatic send_item(input logic [deq_pkg::OP_W-1:0] op,
                             input logic [deq_pkg::POS_W-1:0] pos,
                             input logic [deq_pkg::VAL_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_operation <= op;
        s_position  <= pos;
        s_value     <= val;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
    endtask

    function automatic logic [deq_pkg::POS_W-1:0] pick_position(
        input logic [deq_pkg::OP_W-1:0] op);
        if ($urandom_range(15) == 0)
            return 7'($urandom_range(127));
        if (op == deq_pkg::OP_INSERT_AT)
            return 7'($urandom_range(shadow_count));
        return (shadow_count == 0) ? 7'd0 : 7'($urandom_range(shadow_count - 1));
    endfunction

    task automatic send_random_op(input int grow_pct);
        logic [deq_pkg::OP_W-1:0] op;
        if ($urandom_range(99) >= 90) begin
            op = ($urandom_range(9) == 0) ? OP_UNDEFINED : deq_pkg::OP_READ_AT;
        end else if ($urandom_range(99) < grow_pct) begin
            case ($urandom_range(2))
                0:       op = deq_pkg::OP_PUSH_BACK;
                1:       op = deq_pkg::OP_PUSH_FRONT;
                default: op = deq_pkg::OP_INSERT_AT;
            endcase
        end else begin
            case ($urandom_range(2))
                0:       op = deq_pkg::OP_POP_BACK;
                1:       op = deq_pkg::OP_POP_FRONT;
                default: op = deq_pkg::OP_ERASE_AT;
            endcase
        end
        send_item(op, pick_position(op), $urandom());
    endtask

    task automatic test_empty_queue();
        send_item(deq_pkg::OP_POP_BACK,  7'd0,   32'h0);
        send_item(deq_pkg::OP_POP_FRONT, 7'd0,   32'h0);
        send_item(deq_pkg::OP_READ_AT,   7'd0,   32'h0);
        send_item(deq_pkg::OP_ERASE_AT,  7'd0,   32'h0);
        send_item(deq_pkg::OP_INSERT_AT, 7'd1,   32'hFFFF_FFFF);
        send_item(OP_UNDEFINED,          7'd127, 32'hFFFF_FFFF);
    endtask

    task automatic test_end_and_index_ops();
        send_item(deq_pkg::OP_PUSH_BACK,  7'd0,   32'h0000_0000);
        send_item(deq_pkg::OP_PUSH_FRONT, 7'd0,   32'hFFFF_FFFF);
        send_item(deq_pkg::OP_PUSH_BACK,  7'd0,   32'hA5A5_A5A5);
        send_item(deq_pkg::OP_READ_AT,    7'd0,   32'h0);
        send_item(deq_pkg::OP_READ_AT,    7'd1,   32'h0);
        send_item(deq_pkg::OP_READ_AT,    7'd2,   32'h0);
        send_item(deq_pkg::OP_READ_AT,    7'd3,   32'h0);
        send_item(deq_pkg::OP_READ_AT,    7'd127, 32'h0);
        send_item(deq_pkg::OP_INSERT_AT,  7'd3,   32'h5A5A_5A5A);
        send_item(deq_pkg::OP_INSERT_AT,  7'd0,   32'h1234_5678);
        send_item(deq_pkg::OP_INSERT_AT,  7'd2,   32'h8765_4321);
        send_item(deq_pkg::OP_INSERT_AT,  7'd7,   32'hDEAD_BEEF);
        send_item(deq_pkg::OP_ERASE_AT,   7'd1,   32'h0);
        send_item(deq_pkg::OP_ERASE_AT,   7'd5,   32'h0);
        send_item(deq_pkg::OP_ERASE_AT,   7'd0,   32'h0);
        send_item(deq_pkg::OP_POP_BACK,   7'd0,   32'h0);
        send_item(deq_pkg::OP_POP_FRONT,  7'd0,   32'h0);
    endtask

    task automatic test_full_queue();
        while (shadow_count < DEPTH)
            send_random_op(100);
        send_item(deq_pkg::OP_PUSH_BACK,  7'd0,   $urandom());
        send_item(deq_pkg::OP_PUSH_FRONT, 7'd0,   $urandom());
        send_item(deq_pkg::OP_INSERT_AT,  7'd0,   $urandom());
        send_item(deq_pkg::OP_INSERT_AT,  7'd100, $urandom());
        send_item(deq_pkg::OP_READ_AT,    7'd63,  32'h0);
        send_item(deq_pkg::OP_READ_AT,    7'd64,  32'h0);
        send_item(deq_pkg::OP_ERASE_AT,   7'd63,  32'h0);
        send_item(deq_pkg::OP_ERASE_AT,   7'd0,   32'h0);
        send_item(deq_pkg::OP_INSERT_AT,  7'd32,  $urandom());
        send_item(deq_pkg::OP_PUSH_FRONT, 7'd0,   $urandom());
        while (shadow_count != 0)
            send_random_op(0);
    endtask

    // random walk whose drift flips at the empty and full ends
    task automatic test_random_traffic(input int n_items);
        bit filling;
        filling = 1'b1;
        for (int n = 0; n < n_items; n++) begin
            if (shadow_count == DEPTH)
                filling = 1'b0;
            else if (shadow_count == 0)
                filling = 1'b1;
            send_random_op(filling ? 70 : 30);
        end
    endtask

    initial begin
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;

        send_idle_pct = 36;
        recv_idle_pct = 65;
        test_empty_queue();
        test_end_and_index_ops();
        test_full_queue();
        test_random_traffic(300);

        send_idle_pct = 65;
        recv_idle_pct = 36;
        test_random_traffic(300);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic(300);

        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);
        if (err_count == 0 && pending_results.size() == 0) begin
            $display("[double_ended_queue] OK");
        end else begin
            $display("[double_ended_queue] ERROR");
        end
        $finish;
    end

endmodule
